@@ rtl/lkv_pkg.sv @@
package lkv_pkg;

    // sizes of the store
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    // capacity register
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // stream widths
    localparam int S_DATA_W = KEY_W + VAL_W;
    localparam int M_DATA_W = VAL_W + KEY_W;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

@@ rtl/lkv_ctrl.sv @@
module lkv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output lkv_pkg::cmd_t cmd
);

    lkv_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lkv_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = lkv_pkg::ST_UPDATE;
                end
            end
            lkv_pkg::ST_UPDATE: begin
                // wait until the output register can take the result
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid: set on commit, cleared on transfer
    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/lkv_datapath.sv @@
module lkv_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic [lkv_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [0:0]                     s_tuser,
    input  lkv_pkg::cmd_t                  cmd,
    output logic [lkv_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser
);

    // entry storage
    logic [lkv_pkg::KEY_W-1:0]   key_reg   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]   value_reg [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0] valid_reg;
    logic [lkv_pkg::IDX_W-1:0]   rank_reg  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::CNT_W-1:0]   used_reg;
    logic [lkv_pkg::CAP_W-1:0]   cap_reg;

    // captured item and lookup results
    logic                        op_reg;
    logic [lkv_pkg::KEY_W-1:0]   key_in_reg;
    logic [lkv_pkg::VAL_W-1:0]   value_in_reg;
    logic                        hit_reg;
    logic                        full_reg;
    logic [lkv_pkg::IDX_W-1:0]   slot_reg;
    logic [lkv_pkg::VAL_W-1:0]   found_value_reg;
    logic [lkv_pkg::IDX_W-1:0]   found_rank_reg;

    // output registers
    logic                        out_hit_reg;
    logic                        out_evicted_reg;
    logic [lkv_pkg::VAL_W-1:0]   out_read_value_reg;
    logic [lkv_pkg::KEY_W-1:0]   out_evicted_key_reg;

    // lookup logic
    logic [lkv_pkg::KEY_W-1:0]   in_key;
    logic [lkv_pkg::VAL_W-1:0]   in_value;
    logic                        match_any;
    logic [lkv_pkg::IDX_W-1:0]   match_idx;
    logic [lkv_pkg::IDX_W-1:0]   victim_idx;
    logic [lkv_pkg::IDX_W-1:0]   free_idx;
    logic [lkv_pkg::IDX_W-1:0]   oldest_rank;
    logic [lkv_pkg::CMP_W-1:0]   cap_ext;
    logic [lkv_pkg::CMP_W-1:0]   eff_cap;
    logic                        full;
    logic                        evict;
    logic                        put_miss;

    assign in_key   = s_tdata[lkv_pkg::KEY_W-1:0];
    assign in_value = s_tdata[lkv_pkg::S_DATA_W-1:lkv_pkg::KEY_W];

    // effective capacity: zero acts as one, saturates at the depth
    always_comb begin
        cap_ext = lkv_pkg::CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = lkv_pkg::CMP_W'(1);
        end else if (cap_ext > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
            eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = (lkv_pkg::CMP_W'(used_reg) >= eff_cap);
    end

    assign oldest_rank = lkv_pkg::IDX_W'(used_reg - lkv_pkg::CNT_W'(1));

    // parallel key compare, victim and free slot search (lowest index wins)
    always_comb begin
        match_any  = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == in_key) begin
                match_any = 1'b1;
                match_idx = lkv_pkg::IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == oldest_rank) begin
                victim_idx = lkv_pkg::IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

    // capture the item and its lookup
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg          <= s_tuser[0];
            key_in_reg      <= in_key;
            value_in_reg    <= in_value;
            hit_reg         <= match_any;
            full_reg        <= full;
            found_value_reg <= value_reg[match_idx];
            found_rank_reg  <= rank_reg[match_idx];
            if (match_any) begin
                slot_reg <= match_idx;
            end else if (full) begin
                slot_reg <= victim_idx;
            end else begin
                slot_reg <= free_idx;
            end
        end
    end

    assign put_miss = (op_reg == lkv_pkg::OP_PUT) && !hit_reg;
    assign evict    = put_miss && full_reg;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // valid bits, recency ranks and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            if (hit_reg) begin
                // promote: younger entries age by one
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) == slot_reg) begin
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i] && rank_reg[i] < found_rank_reg) begin
                        rank_reg[i] <= rank_reg[i] + lkv_pkg::IDX_W'(1);
                    end
                end
            end else if (put_miss) begin
                // insert as most recent, replacing the victim when full
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) == slot_reg) begin
                        rank_reg[i]  <= '0;
                        valid_reg[i] <= 1'b1;
                    end else if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + lkv_pkg::IDX_W'(1);
                    end
                end
                if (!full_reg) begin
                    used_reg <= used_reg + lkv_pkg::CNT_W'(1);
                end
            end
        end
    end

    // key and value storage
    always_ff @(posedge aclk) begin
        if (cmd.commit && op_reg == lkv_pkg::OP_PUT) begin
            value_reg[slot_reg] <= value_in_reg;
            if (!hit_reg) begin
                key_reg[slot_reg] <= key_in_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg     <= hit_reg;
            out_evicted_reg <= evict;
            if (evict) begin
                out_evicted_key_reg <= key_reg[slot_reg];
            end else begin
                out_evicted_key_reg <= '0;
            end
            if (op_reg == lkv_pkg::OP_PUT) begin
                out_read_value_reg <= '0;
            end else if (hit_reg) begin
                out_read_value_reg <= found_value_reg;
            end else begin
                out_read_value_reg <= '1;
            end
        end
    end

    assign m_tdata = {out_evicted_key_reg, out_read_value_reg};
    assign m_tuser = {out_evicted_reg, out_hit_reg};

endmodule

@@ rtl/lru_key_value_cache.sv @@
// one item at a time: key compare in the accept cycle, then the rank and entry
// update cycle that loads the output register; no new item is taken until the
// update is done, and the result is valid once the output register is loaded
// a waiting result holds the update cycle until it is taken
// reset (aresetn low, synchronous): all entries invalid, ranks and count zero,
// capacity 16, no result pending
module lru_key_value_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]     cfg_wr_data,   // capacity_in_use
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lkv_pkg::S_DATA_W-1:0]  s_tdata,       // key, value
    input  logic [0:0]                    s_tuser,       // operation
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lkv_pkg::M_DATA_W-1:0]  m_tdata,       // read_value, evicted_key
    output logic [1:0]                    m_tuser        // hit, evicted
);

    lkv_pkg::cmd_t cmd;

    // controller
    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath
    lkv_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // one item at a time: no new transfer right after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // with a free output, the result is valid once the update state has loaded the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
        else $error("result missing after input transfer");

    // an eviction only happens on a missing put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("eviction reported together with a hit");

endmodule
